// ===== src/kldtc_pkg.sv =====
// ----------------------------------------------------------------------------
// kldtc_pkg
// shared widths, constants, command types and helpers for the divergence unit
// ----------------------------------------------------------------------------
package kldtc_pkg;

    localparam int SAMPLE_FRAC_BITS = 16;
    localparam int SUM_BITS         = 32;

    localparam int SAMPLE_BITS = SAMPLE_FRAC_BITS + 1;
    localparam int LOG_FRAC    = 16;
    localparam int MANT_ONE    = 30;
    localparam int MANT_W      = MANT_ONE + 1;
    localparam int SQ_W        = 2 * MANT_W;
    localparam int LOG_INT_W   = $clog2(SAMPLE_BITS);
    localparam int LOG_W       = LOG_INT_W + LOG_FRAC;
    localparam int DIFF_W      = LOG_W + 1;
    localparam int LN2_W       = 17;
    localparam int LNP_W       = DIFF_W + LN2_W;
    localparam int TP_W        = SAMPLE_BITS + 1 + DIFF_W;
    localparam int TERM_W      = TP_W - SAMPLE_FRAC_BITS;
    localparam int ADD_W       = SUM_BITS + 1;
    localparam int DIV_W       = 32;
    localparam int CMP_W       = (SUM_BITS > DIV_W) ? SUM_BITS : DIV_W;
    localparam int SQ_CNT_W    = $clog2(LOG_FRAC);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_DIVERGENCE_LIMIT = '0;

    localparam logic signed [DIV_W-1:0] LIMIT_RESET = 32'sd3277;
    localparam logic signed [LN2_W-1:0] LN2_Q16     = 17'sd45426;

    typedef struct packed {
        logic load;
        logic square;
        logic log_diff;
        logic term;
        logic acc;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

    // position of the leading one
    function automatic logic [LOG_INT_W-1:0] lead_one(input logic [SAMPLE_BITS-1:0] x);
        logic [LOG_INT_W-1:0] n;
        n = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (x[i]) begin
                n = LOG_INT_W'(i);
            end
        end
        return n;
    endfunction

    // normalize to Q1.30
    function automatic logic [MANT_W-1:0] normalize(input logic [SAMPLE_BITS-1:0] x,
                                                     input logic [LOG_INT_W-1:0] n);
        logic [MANT_W-1:0] m;
        m = MANT_W'(x) << (MANT_ONE - int'(n));
        return m;
    endfunction

endpackage

// ===== src/kldtc_if.sv =====
// ----------------------------------------------------------------------------
// kldtc stream interfaces
// valid/ready channels for sample pairs and divergence results
// ----------------------------------------------------------------------------
interface kldtc_in_if;
    logic                               valid;
    logic                               ready;
    logic [kldtc_pkg::SAMPLE_BITS-1:0]  p_value;
    logic [kldtc_pkg::SAMPLE_BITS-1:0]  q_value;
    logic                               last_item;

    modport source (output valid, output p_value, output q_value, output last_item,
                    input ready);
    modport sink   (input valid, input p_value, input q_value, input last_item,
                    output ready);
endinterface

interface kldtc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [kldtc_pkg::DIV_W-1:0] divergence;
    logic                               within_limit;
    logic                               saturated;

    modport source (output valid, output divergence, output within_limit,
                    output saturated, input ready);
    modport sink   (input valid, input divergence, input within_limit,
                    input saturated, output ready);
endinterface

// ===== src/kldtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kldtc_ctrl
// sequencer: load, log squaring steps, ln scale, term, accumulate and emit
// ----------------------------------------------------------------------------
module kldtc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kldtc_pkg::t_dp_cmd    o_cmd,
    input  kldtc_pkg::t_dp_status i_status
);
    import kldtc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_LN,
        ST_TERM,
        ST_ACC
    } t_state;

    t_state              r_state, n_state;
    logic [SQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                emit;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign emit        = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == SQ_CNT_W'(LOG_FRAC - 1)) begin
                    n_state = ST_LN;
                end
            end
            ST_LN: begin
                o_cmd.log_diff = 1'b1;
                n_state        = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = ST_ACC;
            end
            ST_ACC: begin
                if (!i_status.last) begin
                    o_cmd.acc = 1'b1;
                    n_state   = ST_IDLE;
                end else if (emit) begin
                    o_cmd.acc   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/kldtc_dp.sv =====
// ----------------------------------------------------------------------------
// kldtc_dp
// datapath: two log2 squaring units, ln scaling, p weighting, saturating sum
// ----------------------------------------------------------------------------
module kldtc_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kldtc_pkg::t_dp_cmd                    i_cmd,
    output kldtc_pkg::t_dp_status                 o_status,
    input  logic [kldtc_pkg::SAMPLE_BITS-1:0]     i_p_value,
    input  logic [kldtc_pkg::SAMPLE_BITS-1:0]     i_q_value,
    input  logic                                  i_last_item,
    input  logic signed [kldtc_pkg::DIV_W-1:0]    i_limit,
    output logic signed [kldtc_pkg::DIV_W-1:0]    o_divergence,
    output logic                                  o_within_limit,
    output logic                                  o_saturated
);
    import kldtc_pkg::*;

    localparam logic signed [LNP_W-1:0] LN_HALF =
        {{(LNP_W - LOG_FRAC){1'b0}}, 1'b1, {(LOG_FRAC - 1){1'b0}}};
    localparam logic signed [TP_W-1:0] TP_HALF =
        {{(TP_W - SAMPLE_FRAC_BITS){1'b0}}, 1'b1, {(SAMPLE_FRAC_BITS - 1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS - 1){1'b0}}};
    localparam logic signed [CMP_W-1:0] DIV_MAX = CMP_W'(32'sh7FFF_FFFF);
    localparam logic signed [CMP_W-1:0] DIV_MIN = CMP_W'(32'sh8000_0000);

    // one squaring step: returns {fraction bit, next mantissa}
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [SQ_W-1:0]   sq;
        logic [MANT_W:0]   top;
        logic [MANT_W:0]   res;
        sq  = SQ_W'(m) * SQ_W'(m);
        top = sq[MANT_ONE + MANT_W : MANT_ONE];
        if (top[MANT_W]) begin
            res = {1'b1, top[MANT_W:1]};
        end else begin
            res = {1'b0, top[MANT_W-1:0]};
        end
        return res;
    endfunction

    logic [SAMPLE_BITS-1:0]   p_clamp, q_clamp;
    logic [SAMPLE_BITS-1:0]   r_p;
    logic [LOG_INT_W-1:0]     r_np, r_nq;
    logic [MANT_W-1:0]        r_mp, r_mq;
    logic [LOG_FRAC-1:0]      r_fp, r_fq;
    logic                     r_last;
    logic signed [DIFF_W-1:0] r_ln;
    logic signed [TERM_W-1:0] r_term;
    logic signed [SUM_BITS-1:0] r_sum;
    logic                     r_ovf;

    logic [MANT_W:0]          step_p, step_q;
    logic signed [DIFF_W-1:0] diff;
    logic signed [LNP_W-1:0]  ln_prod;
    logic signed [TP_W-1:0]   term_prod;
    logic signed [ADD_W-1:0]  add;
    logic                     add_ovf;
    logic signed [SUM_BITS-1:0] sat_sum;
    logic signed [CMP_W-1:0]  ext;
    logic                     clip_hi, clip_lo;
    logic signed [DIV_W-1:0]  div_val;

    assign p_clamp = (i_p_value == '0) ? SAMPLE_BITS'(1) : i_p_value;
    assign q_clamp = (i_q_value == '0) ? SAMPLE_BITS'(1) : i_q_value;

    assign step_p = sq_step(r_mp);
    assign step_q = sq_step(r_mq);

    assign diff      = signed'({1'b0, r_np, r_fp}) - signed'({1'b0, r_nq, r_fq});
    assign ln_prod   = diff * LN2_Q16 + LN_HALF;
    assign term_prod = signed'({1'b0, r_p}) * r_ln + TP_HALF;

    assign add     = ADD_W'(r_sum) + ADD_W'(r_term);
    assign add_ovf = add[SUM_BITS] != add[SUM_BITS-1];
    assign sat_sum = !add_ovf ? add[SUM_BITS-1:0] : (add[SUM_BITS] ? SUM_MIN : SUM_MAX);

    assign ext     = CMP_W'(sat_sum);
    assign clip_hi = ext > DIV_MAX;
    assign clip_lo = ext < DIV_MIN;
    assign div_val = clip_hi ? DIV_MAX[DIV_W-1:0] :
                     clip_lo ? DIV_MIN[DIV_W-1:0] : ext[DIV_W-1:0];

    assign o_status.last = r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p    <= p_clamp;
            r_np   <= lead_one(p_clamp);
            r_nq   <= lead_one(q_clamp);
            r_mp   <= normalize(p_clamp, lead_one(p_clamp));
            r_mq   <= normalize(q_clamp, lead_one(q_clamp));
            r_fp   <= '0;
            r_fq   <= '0;
            r_last <= i_last_item;
        end
        if (i_cmd.square) begin
            r_mp <= step_p[MANT_W-1:0];
            r_mq <= step_q[MANT_W-1:0];
            r_fp <= {r_fp[LOG_FRAC-2:0], step_p[MANT_W]};
            r_fq <= {r_fq[LOG_FRAC-2:0], step_q[MANT_W]};
        end
        if (i_cmd.log_diff) begin
            r_ln <= DIFF_W'(ln_prod >>> LOG_FRAC);
        end
        if (i_cmd.term) begin
            r_term <= TERM_W'(term_prod >>> SAMPLE_FRAC_BITS);
        end
        if (i_cmd.acc && r_last) begin
            o_divergence   <= div_val;
            o_within_limit <= div_val <= i_limit;
            o_saturated    <= r_ovf || add_ovf || clip_hi || clip_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.acc) begin
            if (r_last) begin
                r_sum <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum <= sat_sum;
                r_ovf <= r_ovf || add_ovf;
            end
        end
    end

endmodule

// ===== src/kl_divergence_threshold_check_unit.sv =====
// ----------------------------------------------------------------------------
// kl_divergence_threshold_check_unit
// accumulates p*ln(p/q) over a tensor and checks it against a limit register
//
//   port      dir   handshake      word contents
//   i_in      in    valid/ready    p_value, q_value, last_item
//   o_out     out   valid/ready    divergence, within_limit, saturated
//   apb       in    psel/penable   divergence_limit at byte address 0
//
// each word goes through accept, 16 squaring steps of the two log2
// units, ln scaling, p weighting and the accumulate step
// synchronous active-low reset clears the sum, the flags and sets the limit
// a last word waits in its accumulate step while the result register is full
// ----------------------------------------------------------------------------
module kl_divergence_threshold_check_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    kldtc_in_if.sink                             i_in,
    kldtc_out_if.source                          o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kldtc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [kldtc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [kldtc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import kldtc_pkg::*;

    t_dp_cmd                 cmd;
    t_dp_status              status;
    logic signed [DIV_W-1:0] r_limit;
    logic                    limit_sel;

    assign pready    = 1'b1;
    assign limit_sel = paddr[APB_ADDR_W-1:2] == REG_DIVERGENCE_LIMIT;
    assign prdata    = limit_sel ? APB_DATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && limit_sel) begin
            r_limit <= signed'(pwdata[DIV_W-1:0]);
        end
    end

    kldtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    kldtc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_p_value      (i_in.p_value),
        .i_q_value      (i_in.q_value),
        .i_last_item    (i_in.last_item),
        .i_limit        (r_limit),
        .o_divergence   (o_out.divergence),
        .o_within_limit (o_out.within_limit),
        .o_saturated    (o_out.saturated)
    );

endmodule

// ===== dv/kldtc_checker.sv =====
// ----------------------------------------------------------------------------
// kldtc_checker
// watches the sample and result channels and the register port of the
// divergence unit, predicts each tensor's divergence word and compares
// ----------------------------------------------------------------------------
module kldtc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    kldtc_in_if                                  i_in_mon,
    kldtc_out_if                                 i_out_mon,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic                                 i_pready,
    input  logic [kldtc_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [kldtc_pkg::APB_DATA_W-1:0]     i_pwdata,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import kldtc_pkg::*;

    localparam longint LN2_FIXED = 45426;
    localparam longint SUM_MAX   = (longint'(1) << (SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN   = -SUM_MAX - 1;
    localparam longint DIV_MAX   = (longint'(1) << (DIV_W - 1)) - 1;
    localparam longint DIV_MIN   = -DIV_MAX - 1;

    typedef struct {
        logic signed [DIV_W-1:0] divergence;
        logic                    within_limit;
        logic                    saturated;
    } t_tensor_result;

    t_tensor_result          divergence_q[$];
    longint                  running_sum;
    logic                    overflow_seen;
    logic signed [DIV_W-1:0] divergence_limit;

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // leading one plus squaring steps on a q1.30 mantissa
    function automatic longint log2_fixed(input longint x);
        int          n;
        logic [63:0] m;
        longint      frac;
        n = 0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (x[i]) begin
                n = i;
            end
        end
        m = 64'(x) << (MANT_ONE - n);
        frac = 0;
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> MANT_ONE;
            frac = frac << 1;
            if (m >= (64'd2 << MANT_ONE)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(n) * (longint'(1) << LOG_FRAC) + frac;
    endfunction

    function automatic longint kl_term(input logic [SAMPLE_BITS-1:0] p,
                                       input logic [SAMPLE_BITS-1:0] q);
        longint ps;
        longint qs;
        longint ln_val;
        ps = (p == '0) ? 1 : longint'(p);
        qs = (q == '0) ? 1 : longint'(q);
        ln_val = round_shift((log2_fixed(ps) - log2_fixed(qs)) * LN2_FIXED, LOG_FRAC);
        return round_shift(ps * ln_val, SAMPLE_FRAC_BITS);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_tensor_result got;
        t_tensor_result want;
        longint         sum;
        if (!i_rst_n) begin
            divergence_q.delete();
            running_sum      = 0;
            overflow_seen    = 1'b0;
            divergence_limit = LIMIT_RESET;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[APB_ADDR_W-1:2] == REG_DIVERGENCE_LIMIT) begin
                divergence_limit = $signed(i_pwdata[DIV_W-1:0]);
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                got.divergence   = i_out_mon.divergence;
                got.within_limit = i_out_mon.within_limit;
                got.saturated    = i_out_mon.saturated;
                if (divergence_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word div=%0d", got.divergence));
                end else begin
                    want = divergence_q.pop_front();
                    if (got.divergence !== want.divergence) begin
                        report_mismatch($sformatf("divergence %0d, want %0d",
                                                  got.divergence, want.divergence));
                    end
                    if (got.within_limit !== want.within_limit) begin
                        report_mismatch($sformatf("within_limit %0b, want %0b (div %0d)",
                                                  got.within_limit, want.within_limit,
                                                  want.divergence));
                    end
                    if (got.saturated !== want.saturated) begin
                        report_mismatch($sformatf("saturated %0b, want %0b (div %0d)",
                                                  got.saturated, want.saturated,
                                                  want.divergence));
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                sum = running_sum + kl_term(i_in_mon.p_value, i_in_mon.q_value);
                if (sum > SUM_MAX) begin
                    sum = SUM_MAX;
                    overflow_seen = 1'b1;
                end else if (sum < SUM_MIN) begin
                    sum = SUM_MIN;
                    overflow_seen = 1'b1;
                end
                running_sum = sum;
                if (i_in_mon.last_item) begin
                    if (sum > DIV_MAX) begin
                        sum = DIV_MAX;
                        overflow_seen = 1'b1;
                    end else if (sum < DIV_MIN) begin
                        sum = DIV_MIN;
                        overflow_seen = 1'b1;
                    end
                    want.divergence   = sum[DIV_W-1:0];
                    want.within_limit = (sum <= longint'(divergence_limit));
                    want.saturated    = overflow_seen;
                    divergence_q.push_back(want);
                    running_sum   = 0;
                    overflow_seen = 1'b0;
                end
            end
        end
        o_pending = divergence_q.size();
    end

endmodule

// ===== dv/tb_kl_divergence_threshold_check_unit.sv =====
// ----------------------------------------------------------------------------
// tb_kl_divergence_threshold_check_unit
// drives sample pairs framed into tensors, threshold register writes and
// result back-pressure into the divergence unit; the checker beside it
// predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_kl_divergence_threshold_check_unit;
    import kldtc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int SAMPLE_ONE     = 1 << SAMPLE_FRAC_BITS;

    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_DIVERGENCE_LIMIT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {1'b1, 2'b00};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int send_idle_pct;
    int recv_idle_pct;
    int holds_asked;
    int holds_served;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int pending;

    kldtc_in_if  in_ch ();
    kldtc_out_if out_ch ();

    kl_divergence_threshold_check_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kldtc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (mismatches),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure, long hold-offs counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_pair(input int p, input int q, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.p_value   <= SAMPLE_BITS'(p);
        in_ch.q_value   <= SAMPLE_BITS'(q);
        in_ch.last_item <= last;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let every queued result drain, then the pipeline settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return 0;
        end else if (r < 14) begin
            return SAMPLE_ONE;
        end else if (r < 18) begin
            return SAMPLE_MAX - $urandom_range(3);
        end else if (r < 70) begin
            return $urandom_range(SAMPLE_ONE);
        end else begin
            return $urandom_range(SAMPLE_MAX);
        end
    endfunction

    task automatic send_random_tensors(input int n);
        int sent;
        int len;
        int r;
        int p;
        int q;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 60) begin
                len = $urandom_range(4, 1);
            end else if (r < 90) begin
                len = $urandom_range(16, 5);
            end else begin
                len = $urandom_range(64, 17);
            end
            for (int k = 0; k < len; k++) begin
                p = pick_sample();
                if ($urandom_range(99) < 30) begin
                    q = p + $urandom_range(512) - 256;
                    q = (q < 0) ? 0 : (q > SAMPLE_MAX) ? SAMPLE_MAX : q;
                end else begin
                    q = pick_sample();
                end
                send_pair(p, q, k == len - 1);
                sent++;
            end
        end
    endtask

    function automatic logic [APB_DATA_W-1:0] small_limit();
        int v;
        v = int'($urandom_range(1 << 21)) - (1 << 20);
        return APB_DATA_W'(v);
    endfunction

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.p_value   = '0;
        in_ch.q_value   = '0;
        in_ch.last_item = 1'b0;
        out_ch.ready    = 1'b0;
        holds_asked     = 0;
        holds_served    = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 21;
        recv_idle_pct   = 63;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs under the reset threshold
        send_pair(0, 0, 1'b1);
        send_pair(SAMPLE_ONE, SAMPLE_ONE, 1'b1);
        send_pair(SAMPLE_MAX, 0, 1'b1);
        send_pair(0, SAMPLE_MAX, 1'b1);
        send_pair(SAMPLE_ONE, 0, 1'b0);
        send_pair(0, SAMPLE_ONE, 1'b0);
        send_pair(SAMPLE_ONE, SAMPLE_ONE / 2, 1'b1);
        send_pair(1, 1, 1'b1);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_pair(SAMPLE_ONE / 2, SAMPLE_ONE, 1'b1);
        send_pair(SAMPLE_ONE, SAMPLE_MAX, 1'b1);
        send_pair(SAMPLE_ONE, 1, 1'b0);
        send_pair(SAMPLE_MAX, 1, 1'b0);
        send_pair(SAMPLE_MAX, 2, 1'b1);
        send_pair(1, SAMPLE_MAX, 1'b1);
        send_pair(98304, 16384, 1'b1);
        send_pair(43690, 21845, 1'b0);
        send_pair(21845, 43690, 1'b1);
        send_pair('h15555, 'h0aaaa, 1'b1);
        send_pair('h0aaaa, 'h15555, 1'b1);
        send_pair(3277, 3300, 1'b1);
        drain_results();

        // extremes of the threshold, plus a write to an unmapped register
        write_reg(LIMIT_ADDR, 32'h8000_0000);
        write_reg(SPARE_ADDR, 32'h7fff_ffff);
        send_random_tensors(200);
        drain_results();
        write_reg(LIMIT_ADDR, 32'h7fff_ffff);
        send_random_tensors(80);
        drain_results();

        send_idle_pct = 63;
        recv_idle_pct = 21;
        write_reg(LIMIT_ADDR, small_limit());
        send_random_tensors(300);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(LIMIT_ADDR, 32'h0000_0000);
        holds_asked++;
        send_random_tensors(300);
        drain_results();

        // one long tensor of large positive terms, then back down
        write_reg(LIMIT_ADDR, $urandom);
        for (int k = 0; k < 100; k++) begin
            send_pair($urandom_range(SAMPLE_MAX, 126000), $urandom_range(1), 1'b0);
        end
        for (int k = 0; k < 5; k++) begin
            send_pair(SAMPLE_ONE, SAMPLE_MAX - $urandom_range(15), k == 4);
        end
        drain_results();

        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== kl_divergence_threshold_check_unit.f =====
src/kldtc_pkg.sv
src/kldtc_if.sv
src/kldtc_ctrl.sv
src/kldtc_dp.sv
src/kl_divergence_threshold_check_unit.sv
dv/kldtc_checker.sv
dv/tb_kl_divergence_threshold_check_unit.sv
